// ===== design/approx_float_equal_defines.svh =====
// assertion macros for the approximate float compare block
`ifndef APPROX_FLOAT_EQUAL_DEFINES_SVH
`define APPROX_FLOAT_EQUAL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define AFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define AFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/afe_pkg.sv =====
// types and constants for the approximate float compare block
package afe_pkg;

    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic        expz;
        logic [10:0] exp;
        logic [52:0] mant;
        logic [62:0] mag;
    } t_opnd;

    localparam logic [62:0] SP_EPS2_MAG = 63'h0000_0000_2880_0000;
    localparam logic [62:0] DP_EPS2_MAG = 63'h3970_0000_0000_0000;
    localparam logic [10:0] SP_EMAX_EFF = 11'd254;
    localparam logic [10:0] DP_EMAX_EFF = 11'd2046;
    localparam logic [10:0] SP_EXP_ONES = 11'd255;
    localparam logic [10:0] DP_EXP_ONES = 11'd2047;
    localparam logic [4:0]  SP_ROUND_BASE = 5'd29;
    localparam logic [4:0]  DP_ROUND_BASE = 5'd0;
    localparam logic [5:0]  SP_QUO_SHIFT = 6'd23;
    localparam logic [5:0]  DP_QUO_SHIFT = 6'd52;
    localparam logic [52:0] SP_MAX_MANT = {{24{1'b1}}, 29'd0};
    localparam logic [52:0] DP_MAX_MANT = {53{1'b1}};
    localparam logic [10:0] MANT_TOP = 11'd52;

endpackage

// ===== design/afe_unpack.sv =====
// operand decode into a common wide format
module afe_unpack (
    input  logic [63:0]    i_value,
    input  logic           i_is_double,
    output afe_pkg::t_opnd o_opnd
);

    logic [10:0] exp_f;
    logic [51:0] frac;
    logic        ones;

    always_comb begin
        if (i_is_double) begin
            exp_f = i_value[62:52];
            frac  = i_value[51:0];
            ones  = (exp_f == afe_pkg::DP_EXP_ONES);
            o_opnd.sign = i_value[63];
            o_opnd.mag  = i_value[62:0];
        end else begin
            exp_f = {3'd0, i_value[30:23]};
            frac  = {i_value[22:0], 29'd0};
            ones  = (exp_f == afe_pkg::SP_EXP_ONES);
            o_opnd.sign = i_value[31];
            o_opnd.mag  = {32'd0, i_value[30:0]};
        end
        o_opnd.nan  = ones && (frac != 52'd0);
        o_opnd.inf  = ones && (frac == 52'd0);
        o_opnd.expz = (exp_f == 11'd0);
        o_opnd.zero = (exp_f == 11'd0) && (frac == 52'd0);
        o_opnd.exp  = (exp_f == 11'd0) ? 11'd1 : exp_f;
        o_opnd.mant = {(exp_f != 11'd0), frac};
    end

endmodule

// ===== design/approx_float_equal.sv =====
// top level: four-stage approximate equality of two binary32/binary64 values
//
//  channel  dir  bus                    contents
//  s        in   i_s_tdata / i_s_tuser  operand pair, precision select
//  m        out  o_m_tdata              approximate-equal flag
//
// four register stages: decode and order, align and add, round, final compare
// one beat in and one beat out per cycle while the output is ready
// each stage holds its beat while the next is full and stalled, so bubbles close up
// synchronous active-low reset clears the valid bits only
`include "approx_float_equal_defines.svh"

module approx_float_equal (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // first_value, second_value
    input  logic         i_s_tuser,   // is_double
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata    // approx_equal, zero pad
);

    typedef struct packed {
        logic        dbl;
        logic        nan;
        logic        eq;
        logic        inf;
        logic        zero;
        logic        zero_ok;
        logic        opp;
        logic        bothz;
        logic [10:0] exp_x;
        logic [10:0] exp_y;
        logic [52:0] mant_x;
        logic [52:0] mant_y;
    } t_s1;

    typedef struct packed {
        logic        dbl;
        logic        nan;
        logic        eq;
        logic        inf;
        logic        zero;
        logic        zero_ok;
        logic        opp;
        logic        opp_ok;
        logic        diff_big;
        logic        diff1;
        logic        xmax;
        logic [10:0] k;
        logic [54:0] sum;
        logic [53:0] dif;
    } t_s2;

    typedef struct packed {
        logic        dbl;
        logic        nan;
        logic        eq;
        logic        inf;
        logic        zero;
        logic        zero_ok;
        logic        opp;
        logic        opp_ok;
        logic        diff_big;
        logic        diff1;
        logic        xmax;
        logic        near;
        logic [55:0] lim;
        logic [53:0] dif;
    } t_s3;

    afe_pkg::t_opnd opa, opb, opx, opy;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_out, n_out;
    logic ld1, ld2, ld3, ld4;

    afe_unpack u_unpack_a (
        .i_value     (i_s_tdata[63:0]),
        .i_is_double (i_s_tuser),
        .o_opnd      (opa)
    );

    afe_unpack u_unpack_b (
        .i_value     (i_s_tdata[127:64]),
        .i_is_double (i_s_tuser),
        .o_opnd      (opb)
    );

    assign ld4 = !r_v4 || i_m_tready;
    assign ld3 = !r_v3 || ld4;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;
    assign o_s_tready = ld1;
    assign o_m_tvalid = r_v4;
    assign o_m_tdata = {7'd0, r_out};

    // stage 1: classify and order by magnitude
    always_comb begin
        logic a_ge;
        a_ge = (opa.mag >= opb.mag);
        opx = a_ge ? opa : opb;
        opy = a_ge ? opb : opa;
        n_s1.dbl = i_s_tuser;
        n_s1.nan = opa.nan || opb.nan;
        n_s1.eq = !(opa.nan || opb.nan) &&
            (((opa.sign == opb.sign) && (opa.mag == opb.mag)) || (opa.zero && opb.zero));
        n_s1.inf = opa.inf || opb.inf;
        n_s1.zero = opa.zero || opb.zero;
        n_s1.zero_ok = opx.mag < (i_s_tuser ? afe_pkg::DP_EPS2_MAG : afe_pkg::SP_EPS2_MAG);
        n_s1.opp = (opa.sign != opb.sign);
        n_s1.bothz = opa.expz && opb.expz;
        n_s1.exp_x = opx.exp;
        n_s1.exp_y = opy.exp;
        n_s1.mant_x = opx.mant;
        n_s1.mant_y = opy.mant;
    end

    // stage 2: align the larger operand and form exact sum and difference
    always_comb begin
        logic [10:0] diff;
        logic [53:0] xa;
        diff = r_s1.exp_x - r_s1.exp_y;
        xa = diff[0] ? {r_s1.mant_x, 1'b0} : {1'b0, r_s1.mant_x};
        n_s2.dbl = r_s1.dbl;
        n_s2.nan = r_s1.nan;
        n_s2.eq = r_s1.eq;
        n_s2.inf = r_s1.inf;
        n_s2.zero = r_s1.zero;
        n_s2.zero_ok = r_s1.zero_ok;
        n_s2.opp = r_s1.opp;
        n_s2.diff_big = (diff > 11'd1);
        n_s2.diff1 = diff[0];
        n_s2.xmax = r_s1.exp_x ==
            (r_s1.dbl ? afe_pkg::DP_EMAX_EFF : afe_pkg::SP_EMAX_EFF);
        n_s2.k = r_s1.exp_y - 11'd1;
        n_s2.sum = {1'b0, xa} + {2'd0, r_s1.mant_y};
        n_s2.dif = xa - {1'b0, r_s1.mant_y};
        n_s2.opp_ok = r_s1.bothz && (n_s2.sum[54:52] == 3'd0);
    end

    // stage 3: round the sum to nearest even, test difference below smallest normal
    always_comb begin
        logic [4:0]  rpos;
        logic [54:0] mask, rem, half, unit;
        logic        lsb, up;
        rpos = (r_s2.dbl ? afe_pkg::DP_ROUND_BASE : afe_pkg::SP_ROUND_BASE) +
               (r_s2.sum[54] ? 5'd2 : (r_s2.sum[53] ? 5'd1 : 5'd0));
        mask = (55'd1 << rpos) - 55'd1;
        unit = mask + 55'd1;
        rem = r_s2.sum & mask;
        half = mask ^ (mask >> 1);
        lsb = |(r_s2.sum & unit);
        up = (half != 55'd0) && ((rem > half) || ((rem == half) && lsb));
        n_s3.dbl = r_s2.dbl;
        n_s3.nan = r_s2.nan;
        n_s3.eq = r_s2.eq;
        n_s3.inf = r_s2.inf;
        n_s3.zero = r_s2.zero;
        n_s3.zero_ok = r_s2.zero_ok;
        n_s3.opp = r_s2.opp;
        n_s3.opp_ok = r_s2.opp_ok;
        n_s3.diff_big = r_s2.diff_big;
        n_s3.diff1 = r_s2.diff1;
        n_s3.xmax = r_s2.xmax;
        n_s3.dif = r_s2.dif;
        n_s3.near = (r_s2.k <= afe_pkg::MANT_TOP) &&
            ((r_s2.dif >> 6'(afe_pkg::MANT_TOP - r_s2.k)) == 54'd0);
        n_s3.lim = {1'b0, r_s2.sum & ~mask} + (up ? {1'b0, unit} : 56'd0);
    end

    // stage 4: clamp to largest finite, compare difference with limit times epsilon
    always_comb begin
        logic        ovf, rel;
        logic [52:0] maxm;
        logic [55:0] limc, lh, qmask;
        logic [5:0]  sh;
        ovf = r_s3.xmax && (r_s3.diff1 ? (r_s3.lim[55:54] != 2'd0)
                                       : (r_s3.lim[55:53] != 3'd0));
        maxm = r_s3.dbl ? afe_pkg::DP_MAX_MANT : afe_pkg::SP_MAX_MANT;
        limc = ovf ? (r_s3.diff1 ? {2'd0, maxm, 1'b0} : {3'd0, maxm}) : r_s3.lim;
        sh = r_s3.dbl ? afe_pkg::DP_QUO_SHIFT : afe_pkg::SP_QUO_SHIFT;
        qmask = (56'd1 << sh) - 56'd1;
        lh = limc >> sh;
        rel = ({2'd0, r_s3.dif} < lh) ||
              (({2'd0, r_s3.dif} == lh) && ((limc & qmask) != 56'd0));
        priority if (r_s3.nan) begin
            n_out = 1'b0;
        end else if (r_s3.eq) begin
            n_out = 1'b1;
        end else if (r_s3.inf) begin
            n_out = 1'b0;
        end else if (r_s3.zero) begin
            n_out = r_s3.zero_ok;
        end else if (r_s3.opp) begin
            n_out = r_s3.opp_ok;
        end else if (r_s3.diff_big) begin
            n_out = 1'b0;
        end else if (r_s3.near) begin
            n_out = 1'b1;
        end else begin
            n_out = rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) r_v1 <= i_s_tvalid;
            if (ld2) r_v2 <= r_v1;
            if (ld3) r_v3 <= r_v2;
            if (ld4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) r_s1 <= n_s1;
        if (ld2) r_s2 <= n_s2;
        if (ld3) r_s3 <= n_s3;
        if (ld4) r_out <= n_out;
    end

    `AFE_ASSERT_NEXT(a_accept_fills, i_s_tvalid && o_s_tready, r_v1,
        "accepted beat did not reach stage one")
    `AFE_ASSERT_NOW(a_full_stall, r_v1 && r_v2 && r_v3 && r_v4 && !i_m_tready,
        !o_s_tready, "input taken while every stage is full and stalled")
    `AFE_ASSERT_NOW(a_empty_ready, !r_v4, o_s_tready,
        "input refused with an empty output stage")
    `AFE_ASSERT_NEXT(a_exact_true, r_v3 && ld4 && r_s3.eq && !r_s3.nan, o_m_tdata[0],
        "exactly equal operands gave false")

endmodule
